// ----- rtl/triangle_tangent_frame_assert.svh -----
// Assertion macros shared by the triangle tangent frame RTL.
`ifndef TRIANGLE_TANGENT_FRAME_ASSERT_SVH
`define TRIANGLE_TANGENT_FRAME_ASSERT_SVH
// Property that must hold at every clock edge outside reset.
`define TTF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("assertion failed");
// Condition that must never be seen outside reset.
`define TTF_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error("forbidden condition");
`endif

// ----- rtl/ttf_pkg.sv -----
// Shared types and constants of the triangle tangent frame block.
`timescale 1ns / 1ps
package ttf_pkg;
	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_DET_ZERO  = 2'd1;
	localparam status_t ST_AREA_ZERO = 2'd2;

	localparam int OUT_W         = 16;
	localparam int NUM_VEC       = 9;
	localparam int NUM_IN_FIELDS = 5;
	localparam int NUM_EDGES     = 10;
endpackage

// ----- rtl/ttf_front.sv -----
// Vertex intake: holds two corners and forms triangle edge vectors.
`timescale 1ns / 1ps
module ttf_front #(
	parameter int W = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ttf_pkg::NUM_IN_FIELDS*W-1:0]   in_data,
	output logic                                  push,
	output logic [ttf_pkg::NUM_EDGES*(W+1)-1:0]   push_data,
	input  logic                                  full
);
	localparam int EW = W + 1;

	logic [1:0]                                cnt_q;
	logic [ttf_pkg::NUM_IN_FIELDS*W-1:0]       corner_q [2];
	logic                                      acc;

	function automatic logic signed [EW-1:0] fld(input logic [ttf_pkg::NUM_IN_FIELDS*W-1:0] v,
		input int f);
		fld = EW'(signed'(v[f*W +: W]));
	endfunction

	// a third corner (or the never-seen count of three) completes a triangle
	assign in_ready = !cnt_q[1] || !full;
	assign acc      = in_valid && in_ready;
	assign push     = acc && cnt_q[1];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			push_data[j*EW +: EW]     = fld(corner_q[1], j) - fld(corner_q[0], j);
			push_data[(3+j)*EW +: EW] = fld(in_data, j) - fld(corner_q[0], j);
		end
		push_data[6*EW +: EW] = fld(corner_q[1], 3) - fld(corner_q[0], 3);
		push_data[7*EW +: EW] = fld(corner_q[1], 4) - fld(corner_q[0], 4);
		push_data[8*EW +: EW] = fld(in_data, 3) - fld(corner_q[0], 3);
		push_data[9*EW +: EW] = fld(in_data, 4) - fld(corner_q[0], 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (acc) begin
			cnt_q <= cnt_q[1] ? 2'd0 : cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !cnt_q[1]) begin
			corner_q[cnt_q[0]] <= in_data;
		end
	end
endmodule

// ----- rtl/ttf_queue.sv -----
// Two-entry queue between triangle assembly and the frame engine.
`timescale 1ns / 1ps
`include "triangle_tangent_frame_assert.svh"
module ttf_queue #(
	parameter int DW = 330
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output logic [DW-1:0] data
);
	logic [DW-1:0] mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	`TTF_NEVER(a_q_overflow, push && full)
	`TTF_NEVER(a_q_underflow, pop && !valid)
endmodule

// ----- rtl/ttf_smul.sv -----
// Shared shift-add signed multiplier, one operand bit per cycle.
`timescale 1ns / 1ps
module ttf_smul #(
	parameter int MW = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [MW-1:0] a,
	input  logic signed [MW-1:0] b,
	output logic                 done,
	output logic signed [2*MW-1:0] prod
);
	localparam int CW = $clog2(MW + 1);

	logic [2*MW-1:0] ma_q;
	logic [2*MW-1:0] acc_q;
	logic [MW-1:0]   mb_q;
	logic            neg_q;
	logic            run_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [MW-1:0]   ua;
	logic [MW-1:0]   ub;

	assign ua   = a[MW-1] ? (~a + 1'b1) : a;
	assign ub   = b[MW-1] ? (~b + 1'b1) : b;
	assign done = done_q;
	assign prod = neg_q ? signed'(~acc_q + 1'b1) : signed'(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(MW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= {{MW{1'b0}}, ua};
			mb_q  <= ub;
			acc_q <= '0;
			neg_q <= a[MW-1] ^ b[MW-1];
		end else if (run_q) begin
			if (mb_q[0]) acc_q <= acc_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
	end
endmodule

// ----- rtl/ttf_back.sv -----
// Frame engine: cross products, normalization and binormal, one triangle at a time.
`timescale 1ns / 1ps
`include "triangle_tangent_frame_assert.svh"
module ttf_back #(
	parameter int W = 32,
	parameter int F = 14
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      q_valid,
	input  logic [ttf_pkg::NUM_EDGES*(W+1)-1:0]       q_data,
	output logic                                      q_pop,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [ttf_pkg::NUM_VEC*ttf_pkg::OUT_W-1:0] vec,
	output ttf_pkg::status_t                          status
);
	localparam int EW   = W + 1;
	localparam int MW   = (EW > 31) ? EW : 31;
	localparam int PW   = 2 * MW;
	localparam int AW   = PW + 1;
	localparam int NUMW = 31 + F;
	localparam int CNTW = $clog2(NUMW + 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_PROD    = 4'd1;
	localparam logic [3:0] S_PWAIT   = 4'd2;
	localparam logic [3:0] S_FIX     = 4'd3;
	localparam logic [3:0] S_UMAG    = 4'd4;
	localparam logic [3:0] S_USHIFT  = 4'd5;
	localparam logic [3:0] S_SQRT    = 4'd6;
	localparam logic [3:0] S_DIVINIT = 4'd7;
	localparam logic [3:0] S_DIV     = 4'd8;
	localparam logic [3:0] S_DIVEND  = 4'd9;
	localparam logic [3:0] S_OUT     = 4'd10;

	localparam logic [1:0] MODE_CROSS = 2'd0;
	localparam logic [1:0] MODE_SQ    = 2'd1;
	localparam logic [1:0] MODE_BIN   = 2'd2;

	logic [3:0]             state_q;
	logic [1:0]             mode_q;
	logic [2:0]             k_q;
	logic                   phase_q;
	logic [1:0]             i_q;
	logic                   usel_q;
	logic [CNTW-1:0]        cnt_q;

	logic signed [EW-1:0]   e_q [ttf_pkg::NUM_EDGES];
	logic signed [AW-1:0]   nw_q [3];
	logic signed [AW-1:0]   tw_q [3];
	logic signed [AW-1:0]   det_q;
	logic signed [AW-1:0]   acc_q;
	logic [AW-1:0]          m_q [3];
	logic [2:0]             vneg_q;
	logic [63:0]            sum_q;
	logic [63:0]            x_q;
	logic [63:0]            r_q;
	logic [63:0]            b_q;
	logic [31:0]            n_q;
	logic [NUMW-1:0]        num_q;
	logic [32:0]            rem_q;
	logic signed [15:0]     nq_q [3];
	logic signed [15:0]     tq_q [3];
	logic signed [15:0]     bq_q [3];
	ttf_pkg::status_t       status_q;

	logic signed [MW-1:0]   op_a;
	logic signed [MW-1:0]   op_b;
	logic                   mul_done;
	logic signed [PW-1:0]   mul_prod;
	logic signed [AW-1:0]   prodw;
	logic signed [AW-1:0]   diff;
	logic [AW-1:0]          dmag;
	logic [63:0]            brnd;
	logic [63:0]            sq64;
	logic                   any_big;
	logic                   nw_zero;
	logic                   det_zero;
	logic [63:0]            rb;
	logic                   sge;
	logic [63:0]            x_next;
	logic [63:0]            r_next;
	logic [32:0]            rem_sh;
	logic                   dge;

	function automatic logic [15:0] sat_out(input logic [63:0] mag, input logic neg);
		logic [63:0] lim;
		logic [63:0] m;
		lim = 64'd1 << F;
		m = (mag > lim) ? lim : mag;
		if (neg) begin
			if (m > 64'd32768) m = 64'd32768;
			sat_out = 16'(~m + 64'd1);
		end else begin
			if (m > 64'd32767) m = 64'd32767;
			sat_out = m[15:0];
		end
	endfunction

	ttf_smul #(.MW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_PROD),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// operand select: edge products, squares of the scaled magnitudes, or T x N terms
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (mode_q)
			MODE_SQ: begin
				op_a = MW'({1'b0, m_q[i_q][29:0]});
				op_b = MW'({1'b0, m_q[i_q][29:0]});
			end
			MODE_BIN: begin
				unique case ({k_q, phase_q})
					4'b0000: begin op_a = MW'(tq_q[1]); op_b = MW'(nq_q[2]); end
					4'b0001: begin op_a = MW'(tq_q[2]); op_b = MW'(nq_q[1]); end
					4'b0010: begin op_a = MW'(tq_q[2]); op_b = MW'(nq_q[0]); end
					4'b0011: begin op_a = MW'(tq_q[0]); op_b = MW'(nq_q[2]); end
					4'b0100: begin op_a = MW'(tq_q[0]); op_b = MW'(nq_q[1]); end
					4'b0101: begin op_a = MW'(tq_q[1]); op_b = MW'(nq_q[0]); end
					default: begin op_a = '0; op_b = '0; end
				endcase
			end
			default: begin
				// edges: e1 x,y,z, e2 x,y,z, du1, dv1, du2, dv2
				unique case ({k_q, phase_q})
					4'b0000: begin op_a = MW'(e_q[1]); op_b = MW'(e_q[5]); end
					4'b0001: begin op_a = MW'(e_q[2]); op_b = MW'(e_q[4]); end
					4'b0010: begin op_a = MW'(e_q[2]); op_b = MW'(e_q[3]); end
					4'b0011: begin op_a = MW'(e_q[0]); op_b = MW'(e_q[5]); end
					4'b0100: begin op_a = MW'(e_q[0]); op_b = MW'(e_q[4]); end
					4'b0101: begin op_a = MW'(e_q[1]); op_b = MW'(e_q[3]); end
					4'b0110: begin op_a = MW'(e_q[6]); op_b = MW'(e_q[9]); end
					4'b0111: begin op_a = MW'(e_q[8]); op_b = MW'(e_q[7]); end
					4'b1000: begin op_a = MW'(e_q[9]); op_b = MW'(e_q[0]); end
					4'b1001: begin op_a = MW'(e_q[7]); op_b = MW'(e_q[3]); end
					4'b1010: begin op_a = MW'(e_q[9]); op_b = MW'(e_q[1]); end
					4'b1011: begin op_a = MW'(e_q[7]); op_b = MW'(e_q[4]); end
					4'b1100: begin op_a = MW'(e_q[9]); op_b = MW'(e_q[2]); end
					4'b1101: begin op_a = MW'(e_q[7]); op_b = MW'(e_q[5]); end
					default: begin op_a = '0; op_b = '0; end
				endcase
			end
		endcase
	end

	assign prodw    = AW'(mul_prod);
	assign diff     = acc_q - prodw;
	assign dmag     = diff[AW-1] ? (~diff + 1'b1) : diff;
	assign brnd     = (64'(dmag) + (64'd1 << (F - 1))) >> F;
	assign sq64     = 64'($unsigned(mul_prod));
	assign nw_zero  = (nw_q[0] == '0) && (nw_q[1] == '0) && (nw_q[2] == '0);
	assign det_zero = det_q == '0;

	always_comb begin
		any_big = 1'b0;
		for (int j = 0; j < 3; j++) any_big = any_big | (|m_q[j][AW-1:30]);
	end

	assign rb     = r_q + b_q;
	assign sge    = x_q >= rb;
	assign x_next = sge ? x_q - rb : x_q;
	assign r_next = sge ? (r_q >> 1) + b_q : r_q >> 1;
	assign rem_sh = {rem_q[31:0], num_q[NUMW-1]};
	assign dge    = rem_sh >= {1'b0, n_q};

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = state_q == S_OUT;
	assign status    = status_q;
	assign vec = {bq_q[2], bq_q[1], bq_q[0], tq_q[2], tq_q[1], tq_q[0], nq_q[2], nq_q[1], nq_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_CROSS;
			k_q     <= '0;
			phase_q <= 1'b0;
			i_q     <= '0;
			usel_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					mode_q  <= MODE_CROSS;
					k_q     <= '0;
					phase_q <= 1'b0;
					state_q <= S_PROD;
				end
				S_PROD: state_q <= S_PWAIT;
				S_PWAIT: if (mul_done) begin
					if (mode_q == MODE_SQ) begin
						if (i_q == 2'd2) begin
							cnt_q   <= CNTW'(32);
							state_q <= S_SQRT;
						end else begin
							i_q     <= i_q + 2'd1;
							state_q <= S_PROD;
						end
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						state_q <= S_PROD;
					end else begin
						phase_q <= 1'b0;
						if (mode_q == MODE_CROSS) begin
							if (k_q == 3'd6) begin
								state_q <= S_FIX;
							end else begin
								k_q     <= k_q + 3'd1;
								state_q <= S_PROD;
							end
						end else if (k_q == 3'd2) begin
							state_q <= S_OUT;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= S_PROD;
						end
					end
				end
				S_FIX: if (nw_zero) begin
					state_q <= S_OUT;
				end else begin
					usel_q  <= 1'b0;
					state_q <= S_UMAG;
				end
				S_UMAG: state_q <= S_USHIFT;
				S_USHIFT: if (!any_big) begin
					mode_q  <= MODE_SQ;
					i_q     <= '0;
					state_q <= S_PROD;
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						i_q     <= '0;
						state_q <= S_DIVINIT;
					end
				end
				S_DIVINIT: begin
					cnt_q   <= CNTW'(NUMW);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) state_q <= S_DIVEND;
				end
				S_DIVEND: if (i_q == 2'd2) begin
					if (!usel_q) begin
						if (det_zero) begin
							state_q <= S_OUT;
						end else begin
							usel_q  <= 1'b1;
							state_q <= S_UMAG;
						end
					end else begin
						mode_q  <= MODE_BIN;
						k_q     <= '0;
						phase_q <= 1'b0;
						state_q <= S_PROD;
					end
				end else begin
					i_q     <= i_q + 2'd1;
					state_q <= S_DIVINIT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int j = 0; j < ttf_pkg::NUM_EDGES; j++) e_q[j] <= q_data[j*EW +: EW];
			for (int j = 0; j < 3; j++) begin
				nq_q[j] <= '0;
				tq_q[j] <= '0;
				bq_q[j] <= '0;
			end
			status_q <= ttf_pkg::ST_OK;
		end
		if (state_q == S_PWAIT && mul_done) begin
			if (mode_q == MODE_SQ) begin
				sum_q <= sum_q + sq64;
				x_q   <= sum_q + sq64;
				r_q   <= '0;
				b_q   <= 64'd1 << 62;
			end else if (!phase_q) begin
				acc_q <= prodw;
			end else if (mode_q == MODE_CROSS) begin
				unique case (k_q)
					3'd0: nw_q[0] <= diff;
					3'd1: nw_q[1] <= diff;
					3'd2: nw_q[2] <= diff;
					3'd3: det_q   <= diff;
					3'd4: tw_q[0] <= diff;
					3'd5: tw_q[1] <= diff;
					3'd6: tw_q[2] <= diff;
					default: det_q <= det_q;
				endcase
			end else begin
				bq_q[k_q[1:0]] <= sat_out(brnd, diff[AW-1]);
			end
		end
		if (state_q == S_FIX) begin
			if (nw_zero) begin
				status_q <= ttf_pkg::ST_AREA_ZERO;
			end else if (det_q[AW-1]) begin
				// flip the tangent so it points along +u
				for (int j = 0; j < 3; j++) tw_q[j] <= -tw_q[j];
			end
		end
		if (state_q == S_UMAG) begin
			for (int j = 0; j < 3; j++) begin
				if (usel_q) begin
					m_q[j]    <= tw_q[j][AW-1] ? (~tw_q[j] + 1'b1) : tw_q[j];
					vneg_q[j] <= tw_q[j][AW-1];
				end else begin
					m_q[j]    <= nw_q[j][AW-1] ? (~nw_q[j] + 1'b1) : nw_q[j];
					vneg_q[j] <= nw_q[j][AW-1];
				end
			end
		end
		// scale all magnitudes down together until the largest fits in 30 bits
		if (state_q == S_USHIFT) begin
			if (any_big) begin
				for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] >> 1;
			end else begin
				sum_q <= '0;
			end
		end
		if (state_q == S_SQRT) begin
			x_q <= x_next;
			r_q <= r_next;
			b_q <= b_q >> 2;
			if (cnt_q == CNTW'(1)) n_q <= (r_next == '0) ? 32'd1 : r_next[31:0];
		end
		if (state_q == S_DIVINIT) begin
			num_q <= (NUMW'(m_q[i_q][29:0]) << F) + NUMW'(n_q[31:1]);
			rem_q <= '0;
		end
		if (state_q == S_DIV) begin
			rem_q <= dge ? rem_sh - {1'b0, n_q} : rem_sh;
			num_q <= {num_q[NUMW-2:0], dge};
		end
		if (state_q == S_DIVEND) begin
			if (usel_q) tq_q[i_q] <= sat_out(64'(num_q), vneg_q[i_q]);
			else        nq_q[i_q] <= sat_out(64'(num_q), vneg_q[i_q]);
			if (i_q == 2'd2 && !usel_q && det_zero) status_q <= ttf_pkg::ST_DET_ZERO;
		end
	end

	`TTF_NEVER(a_mul_done_unexpected, mul_done && (state_q != S_PWAIT))
	`TTF_ASSERT(a_area_zero_clears, (out_valid && status_q == ttf_pkg::ST_AREA_ZERO) |-> (nq_q[0] == 16'sd0 && nq_q[1] == 16'sd0 && nq_q[2] == 16'sd0 && tq_q[0] == 16'sd0))
	`TTF_ASSERT(a_det_zero_clears, (out_valid && status_q == ttf_pkg::ST_DET_ZERO) |-> (tq_q[0] == 16'sd0 && tq_q[1] == 16'sd0 && bq_q[0] == 16'sd0 && bq_q[2] == 16'sd0))
endmodule

// ----- rtl/triangle_tangent_frame.sv -----
// Work per triangle, from the third corner to its result, as far as its status allows:
// cross products, squares and binormal terms on the shared bit-serial multiplier, a square
// root and per-component divides for normal and tangent, after a pre-shift to 30 bits.
// The engine takes one triangle at a time; vertices enter one per cycle while the two-entry
// triangle queue has room. Corners 1 and 2 of a triangle are always taken at once.
// Reset: arst_n clears corner count, queue pointers and engine state; no clearing pass.
`timescale 1ns / 1ps
module triangle_tangent_frame #(
	parameter int COORD_WIDTH   = 32,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v (COORD_WIDTH each), zero pad to bytes
	input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// normal_x/y/z, tangent_x/y/z, binormal_x/y/z, 16 bits each
	output logic [143:0]         m_axis_tdata,
	// status: 0 ok, 1 zero UV determinant, 2 zero-area triangle
	output logic [1:0]           m_axis_tuser
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int QW = ttf_pkg::NUM_EDGES * EW;

	logic          push;
	logic [QW-1:0] push_data;
	logic          full;
	logic          q_valid;
	logic [QW-1:0] q_data;
	logic          q_pop;
	ttf_pkg::status_t status;

	// Front: hold two corners, emit edge and UV deltas on the third.
	ttf_front #(.W(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata[ttf_pkg::NUM_IN_FIELDS*COORD_WIDTH-1:0]),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Queue decouples assembly from the slow frame engine.
	ttf_queue #(.DW(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_data)
	);

	// Back: normal, tangent and binormal; result held in its output registers until taken.
	ttf_back #(.W(COORD_WIDTH), .F(OUT_FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.vec       (m_axis_tdata),
		.status    (status)
	);

	assign m_axis_tuser = status;
endmodule

// ----- tb/triangle_tangent_frame_checker.sv -----
// Checker for the triangle tangent frame block: predicts each frame and compares it.
`timescale 1ns / 1ps
module triangle_tangent_frame_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [159:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [143:0] m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	output int           mismatches,
	output int           frames_waiting,
	output int           frames_ok,
	output int           frames_det_zero,
	output int           frames_area_zero
);
	localparam int FRAC = 14;

	typedef logic signed [127:0] wide_t;
	typedef wide_t               wvec_t [3];
	typedef logic signed [15:0]  ovec_t [3];

	typedef struct {
		logic [143:0]     vecs;
		ttf_pkg::status_t status;
	} frame_t;

	frame_t       frame_q [$];
	logic [159:0] corner_store [2];
	int           corners_held;

	function automatic longint clamp_unit(input longint x);
		longint lim;
		lim = longint'(1) << FRAC;
		if (x > lim) x = lim;
		if (x < -lim) x = -lim;
		if (x > 32767) x = 32767;
		if (x < -32768) x = -32768;
		return x;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Scale a nonzero exact vector to unit length in Q1.14.
	function automatic void make_unit(input wvec_t v, output ovec_t o);
		logic [127:0]    mag [3];
		longint unsigned c [3];
		longint unsigned sum, n, q;
		int              top, sh;
		top = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			for (int b = 127; b >= 0; b--) begin
				if (mag[i][b]) begin
					if (b + 1 > top) top = b + 1;
					break;
				end
			end
		end
		sh = top > 30 ? top - 30 : 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = 64'(mag[i] >> sh);
			sum += c[i] * c[i];
		end
		n = floor_sqrt(sum);
		if (n == 0) n = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((c[i] << FRAC) + n / 2) / n;
			o[i] = 16'(clamp_unit(v[i] < 0 ? -longint'(q) : longint'(q)));
		end
	endfunction

	function automatic longint round_down_frac(input longint x);
		longint unsigned m;
		longint q;
		m = x < 0 ? -x : x;
		q = longint'((m + (64'd1 << (FRAC - 1))) >> FRAC);
		return x < 0 ? -q : q;
	endfunction

	function automatic longint coord(input logic [159:0] d, input int idx);
		return longint'($signed(d[32*idx +: 32]));
	endfunction

	// Build the expected frame from the three corners of one triangle.
	function automatic frame_t tangent_frame(input logic [159:0] c0, c1, c2);
		frame_t f;
		wide_t  e1 [3], e2 [3];
		wide_t  du1, dv1, du2, dv2, det;
		wvec_t  nw, tw;
		ovec_t  nq, tq, bq;
		for (int i = 0; i < 3; i++) begin
			e1[i] = coord(c1, i) - coord(c0, i);
			e2[i] = coord(c2, i) - coord(c0, i);
			nq[i] = '0;
			tq[i] = '0;
			bq[i] = '0;
		end
		du1 = coord(c1, 3) - coord(c0, 3);
		dv1 = coord(c1, 4) - coord(c0, 4);
		du2 = coord(c2, 3) - coord(c0, 3);
		dv2 = coord(c2, 4) - coord(c0, 4);
		nw[0] = e1[1] * e2[2] - e1[2] * e2[1];
		nw[1] = e1[2] * e2[0] - e1[0] * e2[2];
		nw[2] = e1[0] * e2[1] - e1[1] * e2[0];
		det = du1 * dv2 - du2 * dv1;
		for (int i = 0; i < 3; i++) begin
			tw[i] = dv2 * e1[i] - dv1 * e2[i];
			if (det < 0) tw[i] = -tw[i];
		end
		if (nw[0] == 0 && nw[1] == 0 && nw[2] == 0) begin
			f.status = ttf_pkg::ST_AREA_ZERO;
		end else begin
			make_unit(nw, nq);
			if (det == 0) begin
				f.status = ttf_pkg::ST_DET_ZERO;
			end else begin
				f.status = ttf_pkg::ST_OK;
				make_unit(tw, tq);
				bq[0] = 16'(clamp_unit(round_down_frac(longint'(tq[1]) * nq[2]
					- longint'(tq[2]) * nq[1])));
				bq[1] = 16'(clamp_unit(round_down_frac(longint'(tq[2]) * nq[0]
					- longint'(tq[0]) * nq[2])));
				bq[2] = 16'(clamp_unit(round_down_frac(longint'(tq[0]) * nq[1]
					- longint'(tq[1]) * nq[0])));
			end
		end
		for (int i = 0; i < 3; i++) begin
			f.vecs[16*i +: 16]     = nq[i];
			f.vecs[16*(3+i) +: 16] = tq[i];
			f.vecs[16*(6+i) +: 16] = bq[i];
		end
		return f;
	endfunction

	assign frames_waiting = frame_q.size();

	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			corners_held     <= 0;
			mismatches       <= 0;
			frames_ok        <= 0;
			frames_det_zero  <= 0;
			frames_area_zero <= 0;
			frame_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (corners_held < 2) begin
					corner_store[corners_held] <= s_axis_tdata;
					corners_held <= corners_held + 1;
				end else begin
					corners_held <= 0;
					want = tangent_frame(corner_store[0], corner_store[1], s_axis_tdata);
					frame_q = {frame_q, want};
					unique case (want.status)
						ttf_pkg::ST_OK:       frames_ok <= frames_ok + 1;
						ttf_pkg::ST_DET_ZERO: frames_det_zero <= frames_det_zero + 1;
						default:              frames_area_zero <= frames_area_zero + 1;
					endcase
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (frame_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected frame %h status %0d", $time,
							m_axis_tdata, m_axis_tuser);
					mismatches <= mismatches + 1;
				end else begin
					want = frame_q.pop_front();
					if (want.vecs !== m_axis_tdata || want.status !== m_axis_tuser) begin
						if (mismatches < 10) begin
							$display("%0t: frame mismatch", $time);
							for (int i = 0; i < 9; i++)
								if (want.vecs[16*i +: 16] !== m_axis_tdata[16*i +: 16])
									$display("  component %0d: expected %0d got %0d", i,
										$signed(want.vecs[16*i +: 16]),
										$signed(m_axis_tdata[16*i +: 16]));
							$display("  status: expected %0d got %0d", want.status,
								m_axis_tuser);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end
endmodule

// ----- tb/triangle_tangent_frame_tb.sv -----
// Top of the triangle tangent frame testbench: clock, reset, vertex stimulus and verdict.
`timescale 1ns / 1ps
module triangle_tangent_frame_tb;
	localparam int RANDOM_TRIANGLES = 276;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// pos_x, pos_y, pos_z, tex_u, tex_v, 32 bits each, from bit 0 up
	logic [159:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// normal_x/y/z, tangent_x/y/z, binormal_x/y/z, 16 bits each, from bit 0 up
	logic [143:0] m_axis_tdata;
	// status
	logic [1:0]   m_axis_tuser;

	int mismatches, frames_waiting, frames_ok, frames_det_zero, frames_area_zero;
	int burst_left;

	triangle_tangent_frame uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	triangle_tangent_frame_checker frame_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.s_axis_tdata     (s_axis_tdata),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata),
		.m_axis_tuser     (m_axis_tuser),
		.mismatches       (mismatches),
		.frames_waiting   (frames_waiting),
		.frames_ok        (frames_ok),
		.frames_det_zero  (frames_det_zero),
		.frames_area_zero (frames_area_zero)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Receiver: a free-running tick counter picks a new stall mode at random; one mode never stalls,
	// one stalls lightly, one stalls heavily in long runs.
	int stall_mode, stall_tick, stall_run;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_mode    <= 0;
			stall_tick    <= 0;
			stall_run     <= 0;
		end else begin
			stall_tick <= stall_tick + 1;
			if (stall_tick % 64 == 63) stall_mode <= $urandom_range(0, 2);
			if (stall_run > 0) begin
				stall_run     <= stall_run - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_mode == 0) begin
				m_axis_tready <= 1'b1;
			end else if (stall_mode == 1) begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end else if ($urandom_range(0, 7) == 0) begin
				stall_run     <= $urandom_range(1, 20);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Present one vertex and hold it until its transaction; between bursts, usually idle for a random gap.
	task automatic send_vertex(input longint px, py, pz, tu, tv);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {32'(tv), 32'(tu), 32'(pz), 32'(py), 32'(px)};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic longint rand_coord(input int kind);
		if (kind == 0) return longint'($signed($urandom()));
		if (kind == 1) return longint'($signed($urandom_range(0, 32'h001F_FFFF))) - 32'h0010_0000;
		return longint'($urandom_range(0, 600)) - 300;
	endfunction

	// Random triangle; degenerate kinds place a corner on a line through the others.
	task automatic send_random_triangle();
		longint p [3][3], uv [3][2];
		int     scale, shape;
		shape = $urandom_range(0, 9);
		scale = (shape < 3) ? 0 : ($urandom_range(0, 1) ? 1 : 2);
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) p[k][i] = rand_coord(scale);
			for (int i = 0; i < 2; i++) uv[k][i] = rand_coord(scale);
		end
		if (shape == 8 || shape == 9) begin
			scale = (shape == 9) ? 2 : 1;
			for (int i = 0; i < 3; i++) begin
				p[0][i] = rand_coord(2);
				p[1][i] = rand_coord(2);
				p[2][i] = p[0][i] + scale * (p[1][i] - p[0][i]);
			end
		end
		if (shape == 7 || shape == 9) begin
			for (int i = 0; i < 2; i++) begin
				uv[0][i] = rand_coord(2);
				uv[1][i] = rand_coord(2);
				uv[2][i] = uv[0][i] - 3 * (uv[1][i] - uv[0][i]);
			end
		end
		for (int k = 0; k < 3; k++)
			send_vertex(p[k][0], p[k][1], p[k][2], uv[k][0], uv[k][1]);
	endtask

	initial begin
		longint one, hi, lo;
		one = 64'sd65536;
		hi  = 64'sh7FFF_FFFF;
		lo  = -64'sh8000_0000;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		burst_left    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unit right triangle with matching UVs.
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(one, 0, 0, one, 0);
		send_vertex(0, one, 0, 0, one);
		// Zero area: all corners coincide.
		send_vertex(one, one, one, 0, 0);
		send_vertex(one, one, one, one, 0);
		send_vertex(one, one, one, 0, one);
		// Zero area and zero UV determinant together.
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(one, 2 * one, 3 * one, one, one);
		send_vertex(2 * one, 4 * one, 6 * one, 2 * one, 2 * one);
		// Zero UV determinant only: identical UVs.
		send_vertex(0, 0, 0, 5, 7);
		send_vertex(one, 0, one, 5, 7);
		send_vertex(0, one, -one, 5, 7);
		// Extremes of every field, widest edges.
		send_vertex(lo, lo, lo, lo, lo);
		send_vertex(hi, lo, hi, hi, lo);
		send_vertex(lo, hi, hi, lo, hi);
		send_vertex(hi, hi, hi, hi, hi);
		send_vertex(lo, lo, 0, lo, hi);
		send_vertex(0, hi, lo, hi, lo);
		// Mirrored UVs: negative determinant flips the tangent.
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(one, 0, 0, -one, 0);
		send_vertex(0, 0, one, 0, one);
		// Smallest possible edges.
		send_vertex(-1, -1, -1, 0, 0);
		send_vertex(0, -1, -1, 1, 0);
		send_vertex(-1, 0, -1, 0, -1);

		repeat (RANDOM_TRIANGLES) send_random_triangle();
		s_axis_tvalid <= 1'b0;

		while (frames_waiting != 0) @(posedge clk);
		repeat (1500) @(posedge clk);

		$display("Covered %0d triangles: %0d with full frames, %0d with zero UV determinant,",
			frames_ok + frames_det_zero + frames_area_zero, frames_ok, frames_det_zero);
		$display("and %0d with zero area, under random sender gaps and receiver stalls.",
			frames_area_zero);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d frames outstanding", frames_waiting);
		$display("DONE: errors detected");
		$finish;
	end
endmodule
